>>> rtl/core/mcu_crop_rgb565_to_grayscale_assert.svh
// Assertion macros used by the port-level checker of the crop and grayscale block.
`ifndef MCU_CROP_RGB565_TO_GRAYSCALE_ASSERT_SVH
`define MCU_CROP_RGB565_TO_GRAYSCALE_ASSERT_SVH

// Condition must hold at every edge, reset included.
`define MCRGRAY_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) (expr)) else $error("check failed");

// Implication in the same cycle, ignored while in reset.
`define MCRGRAY_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Implication into the next cycle, ignored while in reset.
`define MCRGRAY_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> rtl/core/mcrgray_pkg.sv
// Shared widths, register codes and luma constants of the crop and grayscale block.
package mcrgray_pkg;

  // Default limits on dimensions
  localparam int MAX_IMAGE_DIM_DEF = 1024;
  localparam int MAX_BLOCK_DIM_DEF = 16;

  // Field widths
  localparam int DIM_W      = 11;  // out_width, out_height
  localparam int BDIM_W     = 5;   // block_width, block_height
  localparam int BLKS_W     = 8;   // block counts and block indices
  localparam int PIX_W      = 4;   // pixel row and column in a block
  localparam int RGB_W      = 16;
  localparam int IDX_W      = 20;
  localparam int GRAY_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Largest luma the weights can produce
  localparam int GRAY_MAX = 250;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH      = 3'd0,
    REG_OUT_HEIGHT     = 3'd1,
    REG_BLOCK_WIDTH    = 3'd2,
    REG_BLOCK_HEIGHT   = 3'd3,
    REG_BLOCKS_PER_ROW = 3'd4,
    REG_BLOCKS_PER_COL = 3'd5
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [DIM_W-1:0]  OUT_WIDTH_RST      = 11'd96;
  localparam logic [DIM_W-1:0]  OUT_HEIGHT_RST     = 11'd96;
  localparam logic [BDIM_W-1:0] BLOCK_WIDTH_RST    = 5'd16;
  localparam logic [BDIM_W-1:0] BLOCK_HEIGHT_RST   = 5'd8;
  localparam logic [BLKS_W-1:0] BLOCKS_PER_ROW_RST = 8'd10;
  localparam logic [BLKS_W-1:0] BLOCKS_PER_COL_RST = 8'd15;

  // BT.709 luma weights, unsigned Q16, summing to 65536
  localparam int W_COEF_W = 16;
  localparam logic [W_COEF_W-1:0] W_RED   = 16'd13933;
  localparam logic [W_COEF_W-1:0] W_GREEN = 16'd46871;
  localparam logic [W_COEF_W-1:0] W_BLUE  = 16'd4732;
  localparam int LUMA_FRAC = 16;

  // Reciprocal of a block dimension, exact for any DIM_W-bit numerator
  localparam int RECIP_SHIFT = DIM_W + BDIM_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

endpackage

>>> rtl/core/mcrgray_luma.sv
// Two-stage RGB565 to BT.709 luma unit with a shared advance enable.
module mcrgray_luma
  import mcrgray_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RGB_W-1:0]  rgb_color,
  output logic [GRAY_W-1:0] luma
);

  localparam int CH_W   = 8;                  // expanded channel width
  localparam int PROD_W = W_COEF_W + CH_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [CH_W-1:0]   red_x, green_x, blue_x;
  logic [PROD_W-1:0] prod_red, prod_green, prod_blue;
  logic [SUM_W-1:0]  luma_sum;

  // Expand 5/6/5 channels to 8 bits (shift left by 3, 2, 3)
  assign red_x   = {rgb_color[15:11], 3'b000};
  assign green_x = {rgb_color[10:5], 2'b00};
  assign blue_x  = {rgb_color[4:0], 3'b000};

  // Stage A: weighted channels
  always_ff @(posedge clk) begin
    if (en) begin
      prod_red   <= PROD_W'(W_RED) * PROD_W'(red_x);
      prod_green <= PROD_W'(W_GREEN) * PROD_W'(green_x);
      prod_blue  <= PROD_W'(W_BLUE) * PROD_W'(blue_x);
    end
  end

  // Stage B: sum and drop the fraction
  assign luma_sum = SUM_W'(prod_red) + SUM_W'(prod_green) + SUM_W'(prod_blue);

  always_ff @(posedge clk) begin
    if (en) begin
      luma <= luma_sum[LUMA_FRAC +: GRAY_W];
    end
  end

endmodule

>>> rtl/core/mcu_crop_rgb565_to_grayscale.sv
// Block-window crop with RGB565 to grayscale conversion: one pixel item per clock while
// pix_stall is low, results come from the result register, and a kept pixel gives one
// result while any other pixel gives none. The path is four pipeline stages (block
// dimension division by reciprocal, window start, window test and in-window offsets, block
// to pixel scaling) plus the result register, which also does the final row times width
// multiply. When the result register is full and stalled, the pipeline keeps moving and the
// next kept pixel to leave it lands in a single-entry skid register; pix_stall is high while
// that entry waits and falls at the edge where it moves into the result register.
// Configuration writes are always taken (cfg_ready stays high) and must be made only while
// no item is in flight.
module mcu_crop_rgb565_to_grayscale
  import mcrgray_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEF,
  parameter int MAX_BLOCK_DIM = MAX_BLOCK_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel input channel
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  logic [BLKS_W-1:0]     block_x,
  input  logic [BLKS_W-1:0]     block_y,
  input  logic [PIX_W-1:0]      pixel_row,
  input  logic [PIX_W-1:0]      pixel_col,
  input  logic [RGB_W-1:0]      rgb_color,
  // result channel
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [IDX_W-1:0]      out_index,
  output logic [GRAY_W-1:0]     gray,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SDIFF_W = DIM_W + 2;     // signed differences of block positions
  localparam int START_W = DIM_W + 1;     // signed window start
  localparam int KPROD_W = DIM_W + RECIP_W;
  localparam int PPROD_W = DIM_W + BDIM_W;
  localparam int IPROD_W = 2 * DIM_W;

  // Configuration registers
  logic [DIM_W-1:0]  out_width, out_height;
  logic [BDIM_W-1:0] block_width, block_height;
  logic [BLKS_W-1:0] blocks_per_row, blocks_per_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width      <= OUT_WIDTH_RST;
      out_height     <= OUT_HEIGHT_RST;
      block_width    <= BLOCK_WIDTH_RST;
      block_height   <= BLOCK_HEIGHT_RST;
      blocks_per_row <= BLOCKS_PER_ROW_RST;
      blocks_per_col <= BLOCKS_PER_COL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OUT_WIDTH:      out_width      <= cfg_data[DIM_W-1:0];
        REG_OUT_HEIGHT:     out_height     <= cfg_data[DIM_W-1:0];
        REG_BLOCK_WIDTH:    block_width    <= cfg_data[BDIM_W-1:0];
        REG_BLOCK_HEIGHT:   block_height   <= cfg_data[BDIM_W-1:0];
        REG_BLOCKS_PER_ROW: blocks_per_row <= cfg_data[BLKS_W-1:0];
        REG_BLOCKS_PER_COL: blocks_per_col <= cfg_data[BLKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions limited to the supported maximum
  logic [DIM_W-1:0]  ow, oh;
  logic [BDIM_W-1:0] bw, bh;

  assign ow = (32'(out_width) > 32'(MAX_IMAGE_DIM))  ? DIM_W'(MAX_IMAGE_DIM)  : out_width;
  assign oh = (32'(out_height) > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM)  : out_height;
  assign bw = (32'(block_width) > 32'(MAX_BLOCK_DIM))  ? BDIM_W'(MAX_BLOCK_DIM) : block_width;
  assign bh = (32'(block_height) > 32'(MAX_BLOCK_DIM)) ? BDIM_W'(MAX_BLOCK_DIM) : block_height;

  // Reciprocal table: ceil(2^RECIP_SHIFT / d), zero for a zero dimension
  logic [RECIP_W-1:0] recip_tab [2**BDIM_W];

  for (genvar d = 0; d < 2**BDIM_W; d++) begin : g_recip
    if (d == 0) begin : g_zero
      assign recip_tab[d] = '0;
    end else begin : g_div
      localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SHIFT) + d - 1) / d);
      assign recip_tab[d] = RECIP;
    end
  end

  // Pipeline advance: held only while the skid entry waits
  logic skid_full;
  logic en;

  assign en        = !skid_full;
  assign pix_stall = skid_full;

  // Luma unit runs beside stages 1 and 2
  logic [GRAY_W-1:0] luma_gray;

  mcrgray_luma u_luma (
    .clk       (clk),
    .en        (en),
    .rgb_color (rgb_color),
    .luma      (luma_gray)
  );

  // Stage 1: capture item, pixel-in-block test, blocks-kept products
  logic               s1_valid;
  logic [BLKS_W-1:0]  s1_bx, s1_by;
  logic [PIX_W-1:0]   s1_prow, s1_pcol;
  logic               s1_in_block;
  logic [KPROD_W-1:0] s1_kx_prod, s1_ky_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bx       <= block_x;
      s1_by       <= block_y;
      s1_prow     <= pixel_row;
      s1_pcol     <= pixel_col;
      s1_in_block <= (bw != '0) && (bh != '0) &&
                     (BDIM_W'(pixel_row) < bh) && (BDIM_W'(pixel_col) < bw);
      s1_kx_prod  <= KPROD_W'(ow) * KPROD_W'(recip_tab[bw]);
      s1_ky_prod  <= KPROD_W'(oh) * KPROD_W'(recip_tab[bh]);
    end
  end

  // Stage 2: blocks kept and window start, halved toward zero
  logic [DIM_W-1:0]          keep_x, keep_y;
  logic signed [SDIFF_W-1:0] diff_x, diff_y, adj_x, adj_y;

  assign keep_x = s1_kx_prod[RECIP_SHIFT +: DIM_W];
  assign keep_y = s1_ky_prod[RECIP_SHIFT +: DIM_W];
  assign diff_x = $signed(SDIFF_W'(blocks_per_row)) - $signed(SDIFF_W'(keep_x));
  assign diff_y = $signed(SDIFF_W'(blocks_per_col)) - $signed(SDIFF_W'(keep_y));
  assign adj_x  = diff_x + $signed(SDIFF_W'(diff_x[SDIFF_W-1]));
  assign adj_y  = diff_y + $signed(SDIFF_W'(diff_y[SDIFF_W-1]));

  logic                      s2_valid;
  logic [BLKS_W-1:0]         s2_bx, s2_by;
  logic [PIX_W-1:0]          s2_prow, s2_pcol;
  logic                      s2_in_block;
  logic [DIM_W-1:0]          s2_keep_x, s2_keep_y;
  logic signed [START_W-1:0] s2_start_x, s2_start_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bx       <= s1_bx;
      s2_by       <= s1_by;
      s2_prow     <= s1_prow;
      s2_pcol     <= s1_pcol;
      s2_in_block <= s1_in_block;
      s2_keep_x   <= keep_x;
      s2_keep_y   <= keep_y;
      s2_start_x  <= START_W'(adj_x >>> 1);
      s2_start_y  <= START_W'(adj_y >>> 1);
    end
  end

  // Stage 3: window test and block offsets inside the window
  logic signed [SDIFF_W-1:0] bx_s, by_s, sx_s, sy_s, ex_s, ey_s;
  logic                      win_x, win_y;

  assign bx_s  = $signed({{(SDIFF_W-BLKS_W){1'b0}}, s2_bx});
  assign by_s  = $signed({{(SDIFF_W-BLKS_W){1'b0}}, s2_by});
  assign sx_s  = SDIFF_W'(s2_start_x);
  assign sy_s  = SDIFF_W'(s2_start_y);
  assign ex_s  = sx_s + $signed(SDIFF_W'(s2_keep_x));
  assign ey_s  = sy_s + $signed(SDIFF_W'(s2_keep_y));
  assign win_x = (bx_s >= sx_s) && (bx_s < ex_s);
  assign win_y = (by_s >= sy_s) && (by_s < ey_s);

  logic             s3_valid;
  logic             s3_keep;
  logic [DIM_W-1:0] s3_dx, s3_dy;
  logic [PIX_W-1:0] s3_prow, s3_pcol;
  logic [GRAY_W-1:0] s3_gray;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_keep <= s2_in_block && win_x && win_y;
      s3_dx   <= DIM_W'(bx_s - sx_s);
      s3_dy   <= DIM_W'(by_s - sy_s);
      s3_prow <= s2_prow;
      s3_pcol <= s2_pcol;
      s3_gray <= luma_gray;
    end
  end

  // Stage 4: pixel column and row in the output image
  logic [PPROD_W-1:0] px_prod, py_prod;

  assign px_prod = PPROD_W'(s3_dx) * PPROD_W'(bw);
  assign py_prod = PPROD_W'(s3_dy) * PPROD_W'(bh);

  logic              s4_valid;
  logic              s4_keep;
  logic [DIM_W-1:0]  s4_cur_x, s4_cur_y;
  logic [GRAY_W-1:0] s4_gray;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_keep  <= s3_keep;
      s4_cur_x <= DIM_W'(px_prod + PPROD_W'(s3_pcol));
      s4_cur_y <= DIM_W'(py_prod + PPROD_W'(s3_prow));
      s4_gray  <= s3_gray;
    end
  end

  // Valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pix_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Flat index of the leaving item; only kept pixels reach the result side
  logic [IPROD_W-1:0] row_prod;
  logic               lv;
  logic [IDX_W-1:0]   l_index;

  assign row_prod = IPROD_W'(s4_cur_y) * IPROD_W'(ow);
  assign l_index  = IDX_W'(row_prod + IPROD_W'(s4_cur_x));
  assign lv       = s4_valid && s4_keep;

  // Result register with a one-entry skid
  logic              load_from_skid, load_from_pipe, load_skid;
  logic [IDX_W-1:0]  skid_index;
  logic [GRAY_W-1:0] skid_gray;

  assign load_from_skid = skid_full && !res_stall;
  assign load_from_pipe = !skid_full && (!res_valid || !res_stall);
  assign load_skid      = !skid_full && res_valid && res_stall && lv;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (load_from_skid) begin
        res_valid <= 1'b1;
        skid_full <= 1'b0;
      end else if (load_from_pipe) begin
        res_valid <= lv;
      end else if (load_skid) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      out_index <= skid_index;
      gray      <= skid_gray;
    end else if (load_from_pipe) begin
      out_index <= l_index;
      gray      <= s4_gray;
    end
    if (load_skid) begin
      skid_index <= l_index;
      skid_gray  <= s4_gray;
    end
  end

endmodule

>>> rtl/core/mcrgray_checker.sv
// Port-level checks of the crop and grayscale block, bound to its top level.
`include "mcu_crop_rgb565_to_grayscale_assert.svh"

module mcrgray_sva
  import mcrgray_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              pix_valid,
  input logic              pix_stall,
  input logic              res_valid,
  input logic              res_stall,
  input logic [IDX_W-1:0]  out_index,
  input logic [GRAY_W-1:0] gray
);

  // Reset leaves no result pending and the input open
  `MCRGRAY_ASSERT_ALWAYS(a_reset_clears, $past(rst) !== 1'b1 || (!res_valid && !pix_stall))

  // A stalled result stays put
  `MCRGRAY_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_index) && $stable(gray))

  // Input backpressure only follows a stalled result
  `MCRGRAY_ASSERT_NOW(a_stall_cause, $rose(pix_stall), $past(res_valid && res_stall))

  // Luma weights cannot exceed their known maximum
  `MCRGRAY_ASSERT_NOW(a_gray_range, res_valid, 32'(gray) <= GRAY_MAX)

endmodule

bind mcu_crop_rgb565_to_grayscale mcrgray_sva u_mcrgray_checker (.*);

>>> tb/mcrgray_checker.sv
// Checker for the crop and grayscale block: predicts kept pixels and compares results.
module mcrgray_checker
  import mcrgray_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  input  logic                  pix_stall,
  input  logic [BLKS_W-1:0]     block_x,
  input  logic [BLKS_W-1:0]     block_y,
  input  logic [PIX_W-1:0]      pixel_row,
  input  logic [PIX_W-1:0]      pixel_col,
  input  logic [RGB_W-1:0]      rgb_color,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  logic [IDX_W-1:0]      out_index,
  input  logic [GRAY_W-1:0]     gray,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    waiting
);

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [GRAY_W-1:0] luma;
  } gray_px_t;

  // shadow copy of the window registers
  logic [DIM_W-1:0]  ow_r, oh_r;
  logic [BDIM_W-1:0] bw_r, bh_r;
  logic [BLKS_W-1:0] bpr_r, bpc_r;

  gray_px_t kept_q[$];
  int       errs = 0;

  // BT.709 luma on the expanded RGB565 channels, Q16 weights, truncated
  function automatic logic [GRAY_W-1:0] luma709(input logic [RGB_W-1:0] c);
    int unsigned r, g, b, sum;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    sum = (r * 8) * W_RED + (g * 4) * W_GREEN + (b * 8) * W_BLUE;
    return GRAY_W'(sum >> LUMA_FRAC);
  endfunction

  // Window test and flat index; returns 1 when the pixel is kept
  function automatic bit crop_pixel(input logic [BLKS_W-1:0] bx, by,
                                    input logic [PIX_W-1:0] prow, pcol,
                                    input logic [RGB_W-1:0] c, output gray_px_t px);
    int ow, oh, bw, bh, rows, cols, bxi, byi, ri, ci;
    int keep_x, keep_y, start_x, start_y;
    longint cur_x, cur_y;
    px = '0;
    ow = ow_r;
    oh = oh_r;
    bw = bw_r;
    bh = bh_r;
    rows = bpr_r;
    cols = bpc_r;
    bxi = bx;
    byi = by;
    ri = prow;
    ci = pcol;
    // oversized dimensions saturate
    if (ow > MAX_IMAGE_DIM_DEF) ow = MAX_IMAGE_DIM_DEF;
    if (oh > MAX_IMAGE_DIM_DEF) oh = MAX_IMAGE_DIM_DEF;
    if (bw > MAX_BLOCK_DIM_DEF) bw = MAX_BLOCK_DIM_DEF;
    if (bh > MAX_BLOCK_DIM_DEF) bh = MAX_BLOCK_DIM_DEF;
    if (bw == 0 || bh == 0) return 0;
    if (ri >= bh || ci >= bw) return 0;
    keep_x = ow / bw;
    keep_y = oh / bh;
    // signed halving, truncates toward zero
    start_x = (rows - keep_x) / 2;
    start_y = (cols - keep_y) / 2;
    if (byi < start_y || byi >= start_y + keep_y) return 0;
    if (bxi < start_x || bxi >= start_x + keep_x) return 0;
    cur_x = longint'(bxi - start_x) * bw + ci;
    cur_y = longint'(byi - start_y) * bh + ri;
    px.index = IDX_W'(cur_y * ow + cur_x);
    px.luma = luma709(c);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    gray_px_t want;
    if (rst) begin
      ow_r = OUT_WIDTH_RST;
      oh_r = OUT_HEIGHT_RST;
      bw_r = BLOCK_WIDTH_RST;
      bh_r = BLOCK_HEIGHT_RST;
      bpr_r = BLOCKS_PER_ROW_RST;
      bpc_r = BLOCKS_PER_COL_RST;
      kept_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OUT_WIDTH:      ow_r = cfg_data;
          REG_OUT_HEIGHT:     oh_r = cfg_data;
          REG_BLOCK_WIDTH:    bw_r = cfg_data[BDIM_W-1:0];
          REG_BLOCK_HEIGHT:   bh_r = cfg_data[BDIM_W-1:0];
          REG_BLOCKS_PER_ROW: bpr_r = cfg_data[BLKS_W-1:0];
          REG_BLOCKS_PER_COL: bpc_r = cfg_data[BLKS_W-1:0];
          default: ;
        endcase
      end
      // compare a taken result with the oldest kept pixel
      if (res_valid && !res_stall) begin
        if (kept_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, got index %0d gray %0d",
                   $time, out_index, gray);
        end else begin
          want = kept_q.pop_front();
          if (out_index !== want.index) begin
            errs++;
            $display("%0t: out_index mismatch: expected %0d, got %0d",
                     $time, want.index, out_index);
          end
          if (gray !== want.luma) begin
            errs++;
            $display("%0t: gray mismatch: expected %0d, got %0d", $time, want.luma, gray);
          end
        end
      end
      // predict a taken pixel
      if (pix_valid && !pix_stall) begin
        if (crop_pixel(block_x, block_y, pixel_row, pixel_col, rgb_color, want))
          kept_q.push_back(want);
      end
    end
    mismatches <= errs;
    waiting <= kept_q.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the crop and grayscale block: clock, reset, stimulus and verdict.
module tb;
  import mcrgray_pkg::*;

  localparam int LIMIT       = 100000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 10;
  // indexes past the last register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  logic [BLKS_W-1:0]     block_x = '0;
  logic [BLKS_W-1:0]     block_y = '0;
  logic [PIX_W-1:0]      pixel_row = '0;
  logic [PIX_W-1:0]      pixel_col = '0;
  logic [RGB_W-1:0]      rgb_color = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic [IDX_W-1:0]      out_index;
  logic [GRAY_W-1:0]     gray;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int waiting;
  int cycles = 0;
  bit calm = 1'b0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // window settings as last written, used to aim pixels at the window
  int s_ow = OUT_WIDTH_RST;
  int s_oh = OUT_HEIGHT_RST;
  int s_bw = BLOCK_WIDTH_RST;
  int s_bh = BLOCK_HEIGHT_RST;
  int s_bpr = BLOCKS_PER_ROW_RST;
  int s_bpc = BLOCKS_PER_COL_RST;

  mcu_crop_rgb565_to_grayscale dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .block_x(block_x), .block_y(block_y),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .rgb_color(rgb_color),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_index(out_index), .gray(gray),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mcrgray_checker chk (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .block_x(block_x), .block_y(block_y),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .rgb_color(rgb_color),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_index(out_index), .gray(gray),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .waiting(waiting)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result side: long hold on request, no stalls while calm, otherwise random stalls
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (calm) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < 7);
    end
  end

  // offer one pixel item and hold it until taken, then maybe idle
  task automatic send_pixel(input int bx, by, prow, pcol, input logic [RGB_W-1:0] color);
    @(negedge clk);
    block_x <= BLKS_W'(bx);
    block_y <= BLKS_W'(by);
    pixel_row <= PIX_W'(prow);
    pixel_col <= PIX_W'(pcol);
    rgb_color <= color;
    pix_valid <= 1'b1;
    do @(posedge clk); while (pix_stall);
    if (!calm && $urandom_range(99) < 3)
      repeat ($urandom_range(4, 1)) @(negedge clk) pix_valid <= 1'b0;
  endtask

  // stop sending, wait for every kept pixel, then let the pipeline empty
  task automatic drain();
    @(negedge clk) pix_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_window(input int ow, oh, bw, bh, bpr, bpc);
    drain();
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    write_reg(REG_BLOCK_WIDTH, bw);
    write_reg(REG_BLOCK_HEIGHT, bh);
    write_reg(REG_BLOCKS_PER_ROW, bpr);
    write_reg(REG_BLOCKS_PER_COL, bpc);
    @(negedge clk) cfg_valid <= 1'b0;
    s_ow = ow % 2048;
    s_oh = oh % 2048;
    s_bw = bw % 32;
    s_bh = bh % 32;
    s_bpr = bpr % 256;
    s_bpc = bpc % 256;
  endtask

  // mostly pixels near and inside the window, the rest anywhere
  task automatic random_pixel();
    int ow, oh, bw, bh, kx, ky, sx, sy, bx, by, prow, pcol;
    ow = (s_ow > MAX_IMAGE_DIM_DEF) ? MAX_IMAGE_DIM_DEF : s_ow;
    oh = (s_oh > MAX_IMAGE_DIM_DEF) ? MAX_IMAGE_DIM_DEF : s_oh;
    bw = (s_bw > MAX_BLOCK_DIM_DEF) ? MAX_BLOCK_DIM_DEF : s_bw;
    bh = (s_bh > MAX_BLOCK_DIM_DEF) ? MAX_BLOCK_DIM_DEF : s_bh;
    bx = $urandom_range(255);
    by = $urandom_range(255);
    prow = $urandom_range(15);
    pcol = $urandom_range(15);
    if (bw != 0 && bh != 0 && $urandom_range(99) < 85) begin
      kx = ow / bw;
      ky = oh / bh;
      sx = (s_bpr - kx) / 2;
      sy = (s_bpc - ky) / 2;
      bx = sx - 1 + int'($urandom_range(kx + 1));
      by = sy - 1 + int'($urandom_range(ky + 1));
      if (bx < 0) bx = 0;
      if (bx > 255) bx = 255;
      if (by < 0) by = 0;
      if (by > 255) by = 255;
      if ($urandom_range(9) != 0) begin
        prow = $urandom_range(bh - 1);
        pcol = $urandom_range(bw - 1);
      end
    end
    send_pixel(bx, by, prow, pcol, RGB_W'($urandom_range(16'hFFFF)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset window: blocks 2..7 across, 1..12 down, 16x8 pixels each
    send_pixel(2, 1, 0, 0, 16'h0000);
    send_pixel(7, 12, 7, 15, 16'hFFFF);
    send_pixel(4, 5, 3, 9, 16'hF800);
    send_pixel(3, 6, 2, 2, 16'h07E0);
    send_pixel(5, 7, 1, 1, 16'h001F);
    send_pixel(1, 5, 0, 0, 16'h1234);
    send_pixel(8, 5, 0, 0, 16'h4321);
    send_pixel(4, 0, 0, 0, 16'hFFFF);
    send_pixel(4, 13, 0, 0, 16'hFFFF);
    send_pixel(4, 5, 8, 0, 16'hFFFF);
    send_pixel(4, 5, 15, 15, 16'hFFFF);
    send_pixel(255, 255, 15, 15, 16'hFFFF);
    send_pixel(0, 0, 0, 0, 16'h0000);
    send_pixel(6, 11, 5, 14, 16'hAAAA);
    send_pixel(2, 12, 7, 0, 16'h5555);
    send_pixel(7, 1, 0, 15, 16'h8410);

    // reset values again, receiver held off so the input backs up
    set_window(96, 96, 16, 8, 10, 15);
    hold_reqs++;
    repeat (80) random_pixel();

    // largest in-range window, no idling on either side
    calm = 1'b1;
    set_window(1024, 1024, 16, 16, 64, 64);
    repeat (80) random_pixel();
    calm = 1'b0;

    // every field at its maximum, dimensions saturate
    set_window(2047, 2047, 31, 31, 255, 255);
    repeat (80) random_pixel();

    // smallest window: a single pixel
    set_window(1, 1, 1, 1, 1, 1);
    repeat (40) random_pixel();

    // window wider than the image, negative starts halved from odd differences
    set_window(640, 480, 8, 8, 1, 3);
    repeat (80) random_pixel();

    // zero block width, plus writes to unused indexes
    set_window(100, 50, 0, 8, 10, 15);
    write_reg(REG_SPARE_A, 11'h7FF);
    write_reg(REG_SPARE_B, 11'h555);
    @(negedge clk) cfg_valid <= 1'b0;
    repeat (25) random_pixel();

    // zero block height
    set_window(200, 100, 4, 0, 12, 20);
    repeat (25) random_pixel();

    // zero output width, oversized block height
    set_window(0, 200, 4, 17, 2, 200);
    repeat (25) random_pixel();

    // narrow blocks, pixels often outside their block
    set_window(300, 77, 5, 3, 20, 40);
    repeat (80) random_pixel();

    // random settings
    repeat (4) begin
      set_window($urandom_range(1100, 1), $urandom_range(1100, 1),
                 $urandom_range(17, 1), $urandom_range(17, 1),
                 $urandom_range(255, 1), $urandom_range(255, 1));
      repeat (55) random_pixel();
    end

    drain();
    if (mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
